[sv/mcor_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcor_pkg
// Shared constants, types and the pixel offset function for the midpoint
// circle outline rasterizer.
// ----------------------------------------------------------------------------
package mcor_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int MAX_RADIUS    = 63;
  localparam int STEP_LIMIT    = 46;

  localparam int IN_W  = 40;
  localparam int OUT_W = 144;

  typedef struct packed {
    logic load;
    logic step;
  } mcor_cmd_t;

  typedef struct packed {
    logic last;
  } mcor_status_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] addr;
  } mcor_pix_t;

  // Frame buffer offset of one pixel, zero when off screen.
  function automatic mcor_pix_t pixel_addr(input logic signed [11:0] col,
                                           input logic signed [11:0] row);
    mcor_pix_t   p;
    logic [19:0] off;
    p.ok = (col >= 12'sd0) && (col < $signed(12'(SCREEN_WIDTH))) &&
           (row >= 12'sd0) && (row < $signed(12'(SCREEN_HEIGHT)));
    off = 20'(row[9:0]) * 20'(SCREEN_WIDTH) + 20'(col[9:0]);
    p.addr = p.ok ? off[15:0] : 16'd0;
    return p;
  endfunction

endpackage

[sv/mcor_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcor_dp
// Walk registers (x, y, decision, step count), octant mirroring, offset
// computation and the result register.
// ----------------------------------------------------------------------------
module mcor_dp
  import mcor_pkg::*;
(
  input  logic                clk,
  input  mcor_cmd_t           cmd,
  input  logic signed [10:0]  centre_x,
  input  logic signed [10:0]  centre_y,
  input  logic [5:0]          radius,
  input  logic [7:0]          colour,
  output mcor_status_t        status,
  output logic [OUT_W-1:0]    out_data,
  output logic                out_last
);

  logic signed [10:0] cx;
  logic signed [10:0] cy;
  logic [7:0]         col_reg;
  logic [6:0]         x;
  logic [6:0]         y;
  logic signed [11:0] d;
  logic [5:0]         count;

  logic [15:0]        addr [8];
  logic [7:0]         mask;
  logic [7:0]         pixel_colour;

  logic [6:0]         rs;
  logic signed [11:0] cx_e, cy_e, x_e, y_e, diff;
  logic signed [11:0] cols [4];
  logic signed [11:0] rows [4];
  mcor_pix_t          pix [8];
  logic [6:0]         x_next, y_next;
  logic signed [11:0] d_next;
  logic [5:0]         count_next;

  always_comb begin
    rs = (7'(radius) > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : 7'(radius);
    cx_e = {cx[10], cx};
    cy_e = {cy[10], cy};
    x_e  = $signed({5'b0, x});
    y_e  = $signed({5'b0, y});
    cols[0] = cx_e + x_e;
    cols[1] = cx_e - x_e;
    cols[2] = cx_e + y_e;
    cols[3] = cx_e - y_e;
    rows[0] = cy_e + y_e;
    rows[1] = cy_e - y_e;
    rows[2] = cy_e + x_e;
    rows[3] = cy_e - x_e;
    pix[0] = pixel_addr(cols[0], rows[0]);
    pix[1] = pixel_addr(cols[1], rows[0]);
    pix[2] = pixel_addr(cols[0], rows[1]);
    pix[3] = pixel_addr(cols[1], rows[1]);
    pix[4] = pixel_addr(cols[2], rows[2]);
    pix[5] = pixel_addr(cols[3], rows[2]);
    pix[6] = pixel_addr(cols[2], rows[3]);
    pix[7] = pixel_addr(cols[3], rows[3]);

    diff = x_e - y_e;
    if (d < 12'sd0) begin
      d_next = d + $signed({3'b0, x, 2'b00}) + 12'sd6;
      y_next = y;
    end else begin
      d_next = d + $signed({diff[9:0], 2'b00}) + 12'sd10;
      y_next = y - 7'd1;
    end
    x_next     = x + 7'd1;
    count_next = count + 6'd1;
    // x+1 > y' without the unsigned wrap of y-1 at y = 0
    status.last = ((d < 12'sd0) ? (x >= y) : ((x + 7'd1) >= y)) ||
                  (count_next >= 6'(STEP_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx      <= centre_x;
      cy      <= centre_y;
      col_reg <= colour;
      x       <= 7'd0;
      y       <= rs;
      d       <= 12'sd3 - $signed({4'b0, rs, 1'b0});
      count   <= 6'd0;
    end else if (cmd.step) begin
      x     <= x_next;
      y     <= y_next;
      d     <= d_next;
      count <= count_next;
    end
    if (cmd.step) begin
      for (int i = 0; i < 8; i++) begin
        addr[i] <= pix[i].addr;
        mask[i] <= pix[i].ok;
      end
      pixel_colour <= col_reg;
      out_last     <= status.last;
    end
  end

  assign out_data = {pixel_colour, mask, addr[7], addr[6], addr[5], addr[4],
                     addr[3], addr[2], addr[1], addr[0]};

endmodule

[sv/mcor_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcor_ctrl
// Command sequencer: takes one request, issues one step per free result slot
// until the final step, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mcor_ctrl
  import mcor_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mcor_status_t status,
  output mcor_cmd_t    cmd
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;

  assign in_ready = (state == IDLE);
  assign cmd.load = (state == IDLE) && in_valid;
  assign cmd.step = (state == RUN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) state <= RUN;
        end
        RUN: begin
          if (cmd.step && status.last) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/midpoint_circle_outline_raster.sv]
`timescale 1ns / 1ps
// The request is loaded into the walk registers, and each step then fills the result register.
// A circle has n steps (n = min(r,63)*0.71+1, at most 46); the step loop of the walk
// registers issues one step per cycle while the result register is empty or being taken.
// The single result register lets the next request be taken while the last
// result waits. Reset (rst, synchronous) clears only the sequencer state.
// ----------------------------------------------------------------------------
// midpoint_circle_outline_raster
// Midpoint circle outline walk giving eight mirrored frame buffer offsets
// with an on-screen mask per step.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_raster
  import mcor_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // centre_x[10:0], centre_y[21:11], radius[27:22], colour[35:28], zero pad
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // addr_0..addr_7 [127:0] (16 bits each), write_mask[135:128],
  // pixel_colour[143:136]
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic              m_axis_tlast
);

  mcor_cmd_t    cmd;
  mcor_status_t status;

  mcor_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mcor_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .centre_x ($signed(s_axis_tdata[10:0])),
    .centre_y ($signed(s_axis_tdata[21:11])),
    .radius   (s_axis_tdata[27:22]),
    .colour   (s_axis_tdata[35:28]),
    .status   (status),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a circle is in progress");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
    else $error("sequencer went idle without a final step");

  a_masked_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[128] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("off-screen pixel carries a nonzero offset");

endmodule
